>>> src/rba_pkg.sv
// shared types, widths and reset values for the report driven bitrate adapter
package rba_pkg;

    localparam int JITTER_W = 16;
    localparam int LOSS_W   = 8;
    localparam int CHAN_W   = 16;
    localparam int RATE_W   = 10;
    localparam int LIMIT_W  = 10;
    localparam int COUNT_W  = 4;
    localparam int STEP_W   = 8;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam logic [LOSS_W-1:0]   LOSS_LIMIT_RST   = 8'd10;
    localparam logic [LIMIT_W-1:0]  RISE_LIMIT_RST   = 10'd30;
    localparam logic [LIMIT_W-1:0]  CALM_LIMIT_RST   = 10'd10;
    localparam logic [JITTER_W-1:0] JIT_CEILING_RST  = 16'd60;
    localparam logic [COUNT_W-1:0]  NEEDED_RST       = 4'd3;
    localparam logic [RATE_W-1:0]   RATE_FLOOR_RST   = 10'd16;
    localparam logic [RATE_W-1:0]   RATE_CEILING_RST = 10'd64;
    localparam logic [STEP_W-1:0]   RATE_STEP_RST    = 8'd4;
    localparam logic [RATE_W-1:0]   ASSIGNED_RST     = 10'd64;

    // register map, word index
    typedef enum logic [2:0] {
        REG_LOSS_LIMIT   = 3'd0,
        REG_RISE_LIMIT   = 3'd1,
        REG_CALM_LIMIT   = 3'd2,
        REG_JIT_CEILING  = 3'd3,
        REG_NEEDED       = 3'd4,
        REG_RATE_FLOOR   = 3'd5,
        REG_RATE_CEILING = 3'd6,
        REG_RATE_STEP    = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        NET_STABLE    = 2'd0,
        NET_NEUTRAL   = 2'd1,
        NET_CONGESTED = 2'd2
    } net_state_t;

    typedef struct packed {
        logic [LOSS_W-1:0]   loss_limit;
        logic [LIMIT_W-1:0]  jitter_rise_limit;
        logic [LIMIT_W-1:0]  jitter_calm_limit;
        logic [JITTER_W-1:0] jitter_ceiling;
        logic [COUNT_W-1:0]  stable_reports_needed;
        logic [RATE_W-1:0]   rate_floor;
        logic [RATE_W-1:0]   rate_ceiling;
        logic [STEP_W-1:0]   rate_step;
    } cfg_t;

    typedef struct packed {
        logic [JITTER_W-1:0] jitter;
        logic [LOSS_W-1:0]   fraction_lost;
        logic [CHAN_W-1:0]   channel_limit;
    } report_t;

    typedef struct packed {
        logic [RATE_W-1:0] suggested_rate;
        net_state_t        network_state;
    } result_t;

endpackage

>>> src/rba_cfg.sv
// configuration register file behind the apb port
module rba_cfg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rba_pkg::ADDR_W-1:0]   paddr,
    input  logic [rba_pkg::DATA_W-1:0]   pwdata,
    output logic [rba_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output rba_pkg::cfg_t                cfg
);

    rba_pkg::cfg_t    cfg_reg;
    rba_pkg::reg_idx_t idx;
    logic             wr_en;

    assign idx    = rba_pkg::reg_idx_t'(paddr[rba_pkg::ADDR_W-1:2]);
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // register writes on the access cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.loss_limit            <= rba_pkg::LOSS_LIMIT_RST;
            cfg_reg.jitter_rise_limit     <= rba_pkg::RISE_LIMIT_RST;
            cfg_reg.jitter_calm_limit     <= rba_pkg::CALM_LIMIT_RST;
            cfg_reg.jitter_ceiling        <= rba_pkg::JIT_CEILING_RST;
            cfg_reg.stable_reports_needed <= rba_pkg::NEEDED_RST;
            cfg_reg.rate_floor            <= rba_pkg::RATE_FLOOR_RST;
            cfg_reg.rate_ceiling          <= rba_pkg::RATE_CEILING_RST;
            cfg_reg.rate_step             <= rba_pkg::RATE_STEP_RST;
        end else if (wr_en) begin
            unique case (idx)
                rba_pkg::REG_LOSS_LIMIT:
                    cfg_reg.loss_limit <= pwdata[rba_pkg::LOSS_W-1:0];
                rba_pkg::REG_RISE_LIMIT:
                    cfg_reg.jitter_rise_limit <= pwdata[rba_pkg::LIMIT_W-1:0];
                rba_pkg::REG_CALM_LIMIT:
                    cfg_reg.jitter_calm_limit <= pwdata[rba_pkg::LIMIT_W-1:0];
                rba_pkg::REG_JIT_CEILING:
                    cfg_reg.jitter_ceiling <= pwdata[rba_pkg::JITTER_W-1:0];
                rba_pkg::REG_NEEDED:
                    cfg_reg.stable_reports_needed <= pwdata[rba_pkg::COUNT_W-1:0];
                rba_pkg::REG_RATE_FLOOR:
                    cfg_reg.rate_floor <= pwdata[rba_pkg::RATE_W-1:0];
                rba_pkg::REG_RATE_CEILING:
                    cfg_reg.rate_ceiling <= pwdata[rba_pkg::RATE_W-1:0];
                rba_pkg::REG_RATE_STEP:
                    cfg_reg.rate_step <= pwdata[rba_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // read back, zero extended
    always_comb begin
        unique case (idx)
            rba_pkg::REG_LOSS_LIMIT:
                prdata = {{(rba_pkg::DATA_W-rba_pkg::LOSS_W){1'b0}}, cfg_reg.loss_limit};
            rba_pkg::REG_RISE_LIMIT:
                prdata = {{(rba_pkg::DATA_W-rba_pkg::LIMIT_W){1'b0}},
                          cfg_reg.jitter_rise_limit};
            rba_pkg::REG_CALM_LIMIT:
                prdata = {{(rba_pkg::DATA_W-rba_pkg::LIMIT_W){1'b0}},
                          cfg_reg.jitter_calm_limit};
            rba_pkg::REG_JIT_CEILING:
                prdata = {{(rba_pkg::DATA_W-rba_pkg::JITTER_W){1'b0}},
                          cfg_reg.jitter_ceiling};
            rba_pkg::REG_NEEDED:
                prdata = {{(rba_pkg::DATA_W-rba_pkg::COUNT_W){1'b0}},
                          cfg_reg.stable_reports_needed};
            rba_pkg::REG_RATE_FLOOR:
                prdata = {{(rba_pkg::DATA_W-rba_pkg::RATE_W){1'b0}}, cfg_reg.rate_floor};
            rba_pkg::REG_RATE_CEILING:
                prdata = {{(rba_pkg::DATA_W-rba_pkg::RATE_W){1'b0}}, cfg_reg.rate_ceiling};
            rba_pkg::REG_RATE_STEP:
                prdata = {{(rba_pkg::DATA_W-rba_pkg::STEP_W){1'b0}}, cfg_reg.rate_step};
            default:
                prdata = '0;
        endcase
    end

endmodule

>>> src/rba_core.sv
// rate decision logic and the adapter state (previous jitter, stable count, rate)
module rba_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              upd_en,
    input  rba_pkg::cfg_t     cfg,
    input  rba_pkg::report_t  rpt,
    output rba_pkg::result_t  res
);

    logic [rba_pkg::JITTER_W-1:0] prev_jitter_reg;
    logic [rba_pkg::COUNT_W-1:0]  stable_count_reg;
    logic [rba_pkg::COUNT_W-1:0]  stable_count_next;
    logic [rba_pkg::RATE_W-1:0]   assigned_rate_reg;
    logic [rba_pkg::RATE_W-1:0]   assigned_rate_next;

    logic signed [rba_pkg::JITTER_W:0] gradient;
    logic signed [rba_pkg::JITTER_W:0] rise_lim;
    logic signed [rba_pkg::JITTER_W:0] calm_lim;
    logic                              congested;
    logic                              stable;
    logic [rba_pkg::COUNT_W-1:0]       count_inc;
    logic [rba_pkg::RATE_W-1:0]        half_rate;
    logic [rba_pkg::RATE_W-1:0]        down_rate;
    logic [rba_pkg::RATE_W:0]          up_sum;
    logic [rba_pkg::RATE_W-1:0]        up_rate;
    rba_pkg::net_state_t               state;

    // signed jitter gradient against the previous report
    assign gradient = $signed({1'b0, rpt.jitter}) - $signed({1'b0, prev_jitter_reg});
    assign rise_lim = $signed({{(rba_pkg::JITTER_W+1-rba_pkg::LIMIT_W){1'b0}},
                               cfg.jitter_rise_limit});
    assign calm_lim = $signed({{(rba_pkg::JITTER_W+1-rba_pkg::LIMIT_W){1'b0}},
                               cfg.jitter_calm_limit});

    assign congested = (rpt.fraction_lost > cfg.loss_limit) || (gradient > rise_lim);
    assign stable    = (rpt.fraction_lost == '0) && (gradient < calm_lim) &&
                       (rpt.jitter < cfg.jitter_ceiling);

    // candidate rates for decrease and increase
    assign count_inc = stable_count_reg + rba_pkg::COUNT_W'(1);
    assign half_rate = {1'b0, assigned_rate_reg[rba_pkg::RATE_W-1:1]};
    assign down_rate = (half_rate > cfg.rate_floor) ? half_rate : cfg.rate_floor;
    assign up_sum    = {1'b0, assigned_rate_reg} +
                       {{(rba_pkg::RATE_W+1-rba_pkg::STEP_W){1'b0}}, cfg.rate_step};
    assign up_rate   = (up_sum < {1'b0, cfg.rate_ceiling}) ?
                       up_sum[rba_pkg::RATE_W-1:0] : cfg.rate_ceiling;

    // additive increase, multiplicative decrease
    always_comb begin
        priority if (congested) begin
            assigned_rate_next = down_rate;
            stable_count_next  = '0;
            state              = rba_pkg::NET_CONGESTED;
        end else if (stable) begin
            if (count_inc >= cfg.stable_reports_needed) begin
                assigned_rate_next = up_rate;
                stable_count_next  = '0;
            end else begin
                assigned_rate_next = assigned_rate_reg;
                stable_count_next  = count_inc;
            end
            state = rba_pkg::NET_STABLE;
        end else begin
            assigned_rate_next = assigned_rate_reg;
            stable_count_next  = '0;
            state              = rba_pkg::NET_NEUTRAL;
        end
    end

    // result: lesser of new rate and channel limit
    always_comb begin
        res.network_state = state;
        if ({{(rba_pkg::CHAN_W-rba_pkg::RATE_W){1'b0}}, assigned_rate_next} <
            rpt.channel_limit) begin
            res.suggested_rate = assigned_rate_next;
        end else begin
            res.suggested_rate = rpt.channel_limit[rba_pkg::RATE_W-1:0];
        end
    end

    // state update once per report
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_jitter_reg   <= '0;
            stable_count_reg  <= '0;
            assigned_rate_reg <= rba_pkg::ASSIGNED_RST;
        end else if (upd_en) begin
            prev_jitter_reg   <= rpt.jitter;
            stable_count_reg  <= stable_count_next;
            assigned_rate_reg <= assigned_rate_next;
        end
    end

endmodule

>>> src/report_driven_bitrate_adapter.sv
// top level: report input register, decision core, result register, apb registers
//
//  channel   direction  payload                                handshake
//  s_        in         jitter, fraction_lost, channel_limit     s_valid / s_ready
//  m_        out        suggested_rate, network_state            m_valid / m_ready
//  apb       in/out     8 registers at byte address 4*i          psel / penable, pready=1
//
// one report per cycle sustained while m_ready stays high; a report reaches m_ through
// the input register, then the decision logic into the result register
// synchronous active-low reset clears both stage valids and the adapter state
// s_ready drops only while both the input and the result register are full and m_ready is low
module report_driven_bitrate_adapter (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [rba_pkg::JITTER_W-1:0]   s_jitter,
    input  logic [rba_pkg::LOSS_W-1:0]     s_fraction_lost,
    input  logic [rba_pkg::CHAN_W-1:0]     s_channel_limit,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [rba_pkg::RATE_W-1:0]     m_suggested_rate,
    output logic [1:0]                     m_network_state,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rba_pkg::ADDR_W-1:0]     paddr,
    input  logic [rba_pkg::DATA_W-1:0]     pwdata,
    output logic [rba_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);

    rba_pkg::cfg_t    cfg;
    rba_pkg::report_t rpt_reg;
    rba_pkg::result_t res_next;
    rba_pkg::result_t res_reg;
    logic             in_vld_reg;
    logic             out_vld_reg;
    logic             advance;
    logic             s_xfer;

    rba_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // a report moves into the result register when that register is free or draining
    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;
    assign s_xfer  = s_valid && s_ready;

    rba_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .upd_en  (advance),
        .cfg     (cfg),
        .rpt     (rpt_reg),
        .res     (res_next)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            rpt_reg.jitter        <= s_jitter;
            rpt_reg.fraction_lost <= s_fraction_lost;
            rpt_reg.channel_limit <= s_channel_limit;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_valid          = out_vld_reg;
    assign m_suggested_rate = res_reg.suggested_rate;
    assign m_network_state  = res_reg.network_state;

`ifndef NO_ASSERTIONS
    // input stalls only when both stages are full and the result is held
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_vld_reg && out_vld_reg && !m_ready))
        else $error("input stalled with room in the pipeline");

    // a report leaving the input register always shows up as a result
    a_advance_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("processed report produced no result");

    // a taken result with nothing behind it leaves the output empty
    a_drain_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !in_vld_reg) |=> !m_valid)
        else $error("result repeated after transfer");
`endif

endmodule
